// File: src/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// shared widths and types for the segment / plane intersection pipeline
// ----------------------------------------------------------------------------
package spi_pkg;
   localparam int COORD_W   = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int TERM_W    = 48;
   localparam int SUM_W     = 50;
   localparam int DMAG_W    = SUM_W - 1;
   localparam int TOT_W     = SUM_W;
   localparam int Q_W       = 32;
   localparam int DIV_STEPS = Q_W;
   localparam int EPS_W     = 31;
   localparam int AXES      = 3;
   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

   typedef struct packed {
      logic                                hit;
      logic [AXES-1:0]                     ab_neg;
      logic [AXES-1:0][DIFF_W-1:0]         ab_mag;
      logic [AXES-1:0][COORD_W-1:0]        start;
   } spi_side_type;
endpackage

// File: src/spi_divider.sv
// ----------------------------------------------------------------------------
// spi_divider
// pipelined restoring divider, one quotient bit per stage, q = a*2^32/tot
// ----------------------------------------------------------------------------
module spi_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [spi_pkg::TOT_W-1:0]  in_a,
   input  logic [spi_pkg::TOT_W-1:0]  in_tot,
   input  spi_pkg::spi_side_type      in_side,
   output logic                       out_valid,
   output logic [spi_pkg::Q_W-1:0]    out_q,
   output spi_pkg::spi_side_type      out_side
);
   import spi_pkg::*;

   logic [TOT_W-1:0]   r_ff    [0:DIV_STEPS];
   logic [TOT_W-1:0]   tot_ff  [0:DIV_STEPS];
   logic [Q_W-1:0]     q_ff    [0:DIV_STEPS];
   spi_side_type       side_ff [0:DIV_STEPS];
   logic [DIV_STEPS:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
      if (en) begin
         r_ff[0]    <= in_a;
         tot_ff[0]  <= in_tot;
         q_ff[0]    <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [TOT_W:0]   shl;
      logic             take;
      logic [TOT_W-1:0] r_in;

      always_comb begin
         shl  = {r_ff[k], 1'b0};
         take = shl >= {1'b0, tot_ff[k]};
         r_in = take ? TOT_W'(shl - {1'b0, tot_ff[k]}) : shl[TOT_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (en) begin
            r_ff[k+1]    <= r_in;
            tot_ff[k+1]  <= tot_ff[k];
            q_ff[k+1]    <= {q_ff[k][Q_W-2:0], take};
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[DIV_STEPS];
   assign out_q     = q_ff[DIV_STEPS];
   assign out_side  = side_ff[DIV_STEPS];
endmodule

// File: src/segment_plane_intersection.sv
// path from an accepted req item to rsp_tvalid: stages 1 to 3, the divider, the offset stage, the output register
// throughput: one item per cycle while not stalled; the 32 single-bit divider stages set the depth
// the whole pipeline holds while rsp_tvalid is high and rsp_tready is low
// reset: synchronous, clears all valid bits, epsilon returns to 1
// ----------------------------------------------------------------------------
// segment_plane_intersection
// crossing point of a segment with a plane, signed q16.16
// ----------------------------------------------------------------------------
module segment_plane_intersection (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // seg_start_x/y/z, seg_end_x/y/z, plane_point_x/y/z, normal_x/y/z
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // cross_x, cross_y, cross_z
   output logic [95:0]  rsp_tdata,
   // hit
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [spi_pkg::EPS_W-1:0] csr_data
);
   import spi_pkg::*;

   logic en;
   logic [EPS_W-1:0] eps_ff;

   // stage 1: differences
   logic                       v1_ff;
   logic [AXES-1:0][DIFF_W-1:0] ds_mag_ff, de_mag_ff, ab_mag1_ff;
   logic [AXES-1:0]            ds_neg_ff, de_neg_ff, ab_neg1_ff, n_neg_ff;
   logic [AXES-1:0][COORD_W-1:0] n_mag_ff, start1_ff;
   // stage 2: products
   logic                       v2_ff;
   logic [AXES-1:0][TERM_W-1:0] ta_ff, tb_ff;
   logic [AXES-1:0]            ta_neg_ff, tb_neg_ff;
   logic [AXES-1:0][DIFF_W-1:0] ab_mag2_ff;
   logic [AXES-1:0]            ab_neg2_ff;
   logic [AXES-1:0][COORD_W-1:0] start2_ff;
   // stage 3: sums
   logic                       v3_ff;
   logic signed [SUM_W-1:0]    da_ff, db_ff;
   logic [AXES-1:0][DIFF_W-1:0] ab_mag3_ff;
   logic [AXES-1:0]            ab_neg3_ff;
   logic [AXES-1:0][COORD_W-1:0] start3_ff;
   // divider
   logic [TOT_W-1:0]           a_in, tot_in;
   spi_side_type               side_in, dside;
   logic                       dvalid;
   logic [Q_W-1:0]             dq;
   // offset stage
   logic                       v5_ff;
   spi_side_type               side5_ff;
   logic [AXES-1:0][DIFF_W-1:0] off_ff;
   // output
   logic                       v6_ff, hit6_ff;
   logic [AXES-1:0][COORD_W-1:0] cross_ff;

   assign en         = !v6_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_valid) begin
         eps_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v5_ff <= dvalid;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [DIFF_W-1:0] s, e, p, n, ds, de, ab;
      logic signed [SUM_W-1:0]  sa, sb;
      logic [2*DIFF_W-1:0]      pa, pb;
      logic [DIFF_W+Q_W-1:0]    po;
      if (en) begin
         for (int i = 0; i < AXES; i++) begin
            s  = DIFF_W'(signed'(req_tdata[COORD_W*i +: COORD_W]));
            e  = DIFF_W'(signed'(req_tdata[COORD_W*(3+i) +: COORD_W]));
            p  = DIFF_W'(signed'(req_tdata[COORD_W*(6+i) +: COORD_W]));
            n  = DIFF_W'(signed'(req_tdata[COORD_W*(9+i) +: COORD_W]));
            ds = p - s;
            de = p - e;
            ab = e - s;
            ds_neg_ff[i]  <= ds[DIFF_W-1];
            de_neg_ff[i]  <= de[DIFF_W-1];
            ab_neg1_ff[i] <= ab[DIFF_W-1];
            n_neg_ff[i]   <= n[DIFF_W-1];
            ds_mag_ff[i]  <= ds[DIFF_W-1] ? DIFF_W'(-ds) : DIFF_W'(ds);
            de_mag_ff[i]  <= de[DIFF_W-1] ? DIFF_W'(-de) : DIFF_W'(de);
            ab_mag1_ff[i] <= ab[DIFF_W-1] ? DIFF_W'(-ab) : DIFF_W'(ab);
            n_mag_ff[i]   <= n[DIFF_W-1] ? COORD_W'(-n) : COORD_W'(n);
            start1_ff[i]  <= req_tdata[COORD_W*i +: COORD_W];
         end

         for (int i = 0; i < AXES; i++) begin
            pa = ds_mag_ff[i] * {1'b0, n_mag_ff[i]};
            pb = de_mag_ff[i] * {1'b0, n_mag_ff[i]};
            ta_ff[i]     <= pa[TERM_W+15:16];
            tb_ff[i]     <= pb[TERM_W+15:16];
            ta_neg_ff[i] <= ds_neg_ff[i] ^ n_neg_ff[i];
            tb_neg_ff[i] <= de_neg_ff[i] ^ n_neg_ff[i];
         end
         ab_mag2_ff <= ab_mag1_ff;
         ab_neg2_ff <= ab_neg1_ff;
         start2_ff  <= start1_ff;

         sa = '0;
         sb = '0;
         for (int i = 0; i < AXES; i++) begin
            sa = ta_neg_ff[i] ? sa - SUM_W'(ta_ff[i]) : sa + SUM_W'(ta_ff[i]);
            sb = tb_neg_ff[i] ? sb - SUM_W'(tb_ff[i]) : sb + SUM_W'(tb_ff[i]);
         end
         da_ff      <= sa;
         db_ff      <= sb;
         ab_mag3_ff <= ab_mag2_ff;
         ab_neg3_ff <= ab_neg2_ff;
         start3_ff  <= start2_ff;

         for (int i = 0; i < AXES; i++) begin
            po = dside.ab_mag[i] * dq;
            off_ff[i] <= po[DIFF_W+Q_W-1:Q_W];
         end
         side5_ff <= dside;

         hit6_ff <= side5_ff.hit;
         for (int i = 0; i < AXES; i++) begin
            if (!side5_ff.hit) begin
               cross_ff[i] <= '0;
            end else if (side5_ff.ab_neg[i]) begin
               cross_ff[i] <= COORD_W'(side5_ff.start[i] - off_ff[i][COORD_W-1:0]);
            end else begin
               cross_ff[i] <= COORD_W'(side5_ff.start[i] + off_ff[i][COORD_W-1:0]);
            end
         end
      end
   end

   // snap, classify and feed the divider
   always_comb begin
      logic [DMAG_W-1:0] ma, mb;
      logic              za, zb;
      ma = da_ff[SUM_W-1] ? DMAG_W'(-da_ff) : DMAG_W'(da_ff);
      mb = db_ff[SUM_W-1] ? DMAG_W'(-db_ff) : DMAG_W'(db_ff);
      // an exact zero distance is on the plane even with epsilon zero
      za = (ma == '0) || (ma < DMAG_W'(eps_ff));
      zb = (mb == '0) || (mb < DMAG_W'(eps_ff));
      a_in   = TOT_W'(ma);
      tot_in = TOT_W'(ma) + TOT_W'(mb);
      side_in.hit    = !za && !zb && (da_ff[SUM_W-1] != db_ff[SUM_W-1]);
      side_in.ab_neg = ab_neg3_ff;
      side_in.ab_mag = ab_mag3_ff;
      side_in.start  = start3_ff;
   end

   spi_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_a      (a_in),
      .in_tot    (tot_in),
      .in_side   (side_in),
      .out_valid (dvalid),
      .out_q     (dq),
      .out_side  (dside)
   );

   assign rsp_tvalid = v6_ff;
   assign rsp_tuser  = hit6_ff;
   assign rsp_tdata  = {cross_ff[2], cross_ff[1], cross_ff[0]};
endmodule

// File: src/spi_checker.sv
// ----------------------------------------------------------------------------
// spi_checker
// port level checks for segment_plane_intersection
// ----------------------------------------------------------------------------
module spi_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [95:0]  rsp_tdata,
   input logic         rsp_tuser
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 96'd0)
      else $error("miss with nonzero point");

   a_stall_in: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req taken while pipeline stalled");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");
endmodule

bind segment_plane_intersection spi_checker u_spi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: test/tb_segment_plane_intersection.sv
// ----------------------------------------------------------------------------
// tb_segment_plane_intersection
// random and directed segment / plane queries, checked item by item against a
// behavioral model of the distance, snap, ratio and interpolation arithmetic
// ----------------------------------------------------------------------------
module tb_segment_plane_intersection;
   timeunit 1ns;
   timeprecision 1ps;
   import spi_pkg::*;

   localparam int LATENCY   = 38;
   localparam int MAX_CYCLE = 400000;

   typedef struct packed {
      logic        hit;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } crossing_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [383:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [EPS_W-1:0] csr_data;

   segment_plane_intersection DUT (.*);

   logic [383:0] query_q[$];
   crossing_type crossing_q[$];
   logic [EPS_W-1:0] eps_model;
   int  errors;
   int  hits_seen;
   int  rsp_count;
   int  cycle;
   int  hold_off;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("timeout");
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic signed [63:0] dist_term(logic signed [63:0] p,
         logic signed [63:0] s, logic signed [63:0] n);
      logic signed [63:0] d;
      logic [63:0] m;
      d = p - s;
      m = (((d < 0) ? -d : d) * ((n < 0) ? -n : n)) >> 16;
      return ((d < 0) != (n < 0)) ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [63:0] plane_distance(logic [95:0] pt,
         logic [95:0] pp, logic [95:0] nn);
      logic signed [63:0] sum;
      logic [63:0] mag;
      sum = 0;
      for (int i = 0; i < 3; i++)
         sum += dist_term($signed(pp[32*i +: 32]), $signed(pt[32*i +: 32]),
                          $signed(nn[32*i +: 32]));
      mag = (sum < 0) ? -sum : sum;
      if (mag < eps_model) sum = 0;
      return sum;
   endfunction

   function automatic crossing_type predict_crossing(logic [383:0] q);
      crossing_type res;
      logic signed [63:0] da, db, ab, c;
      logic [63:0] a, tot, r, ratio;
      logic [127:0] off;
      logic [31:0] pt[3];
      res = '0;
      da = plane_distance(q[95:0], q[287:192], q[383:288]);
      db = plane_distance(q[191:96], q[287:192], q[383:288]);
      if (!((da > 0 && db < 0) || (da < 0 && db > 0))) return res;
      a = (da < 0) ? -da : da;
      tot = a + ((db < 0) ? -db : db);
      r = a;
      ratio = 0;
      for (int i = 0; i < 32; i++) begin
         r = r << 1;
         ratio = ratio << 1;
         if (r >= tot) begin
            r -= tot;
            ratio[0] = 1'b1;
         end
      end
      res.hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
         ab = $signed(q[96 + 32*i +: 32]) - $signed(q[32*i +: 32]);
         off = ({64'd0, (ab < 0) ? -ab : ab} * {64'd0, ratio}) >> 32;
         c = (ab < 0) ? $signed(q[32*i +: 32]) - $signed(off[63:0])
                      : $signed(q[32*i +: 32]) + $signed(off[63:0]);
         pt[i] = c[31:0];
      end
      res.x = pt[0];
      res.y = pt[1];
      res.z = pt[2];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at item %0d: %s got %h expected %h", rsp_count, what, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) crossing_q.push_back(predict_crossing(req_tdata));
         if (query_q.size() > 0 && ($urandom_range(0, 3) != 0 || hold_off > 0)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= query_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
            if ($urandom_range(0, 30) == 0) repeat ($urandom_range(5, 30)) @(posedge clock);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (crossing_q.size() == 0) begin
            $display("unexpected result item");
            errors++;
         end else begin
            want = crossing_q.pop_front();
            if (rsp_tuser !== want.hit) report_mismatch("hit", rsp_tuser, want.hit);
            if (rsp_tdata[31:0] !== want.x) report_mismatch("cross_x", rsp_tdata[31:0], want.x);
            if (rsp_tdata[63:32] !== want.y) report_mismatch("cross_y", rsp_tdata[63:32], want.y);
            if (rsp_tdata[95:64] !== want.z) report_mismatch("cross_z", rsp_tdata[95:64], want.z);
            if (want.hit) hits_seen++;
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 20) == 0);
         if ($urandom_range(0, 600) == 0) hold_off <= $urandom_range(20, 60);
      end
   end

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
         default: return $signed($urandom_range(0, 400)) - 200;
      endcase
   endfunction

   function automatic logic [383:0] rand_query();
      logic [383:0] q;
      int mode;
      mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1);
      for (int i = 0; i < 12; i++) q[32*i +: 32] = rand_coord(mode);
      // often put the plane point between the endpoints so crossings occur
      if ($urandom_range(0, 2) != 0)
         for (int i = 0; i < 3; i++)
            q[192 + 32*i +: 32] = ($signed(q[32*i +: 32]) >>> 1) +
                                  ($signed(q[96 + 32*i +: 32]) >>> 1);
      if ($urandom_range(0, 15) == 0) q[383:288] = '0;
      if ($urandom_range(0, 15) == 0) q[191:96] = q[95:0];
      return q;
   endfunction

   function automatic logic [383:0] make_query(int sx, int sy, int sz, int ex, int ey,
         int ez, int px, int py, int pz, int nx, int ny, int nz);
      return {nz, ny, nx, pz, py, px, ez, ey, ex, sz, sy, sx};
   endfunction

   task automatic write_epsilon(logic [EPS_W-1:0] value);
      wait (query_q.size() == 0 && !req_tvalid && crossing_q.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      eps_model = value;
   endtask

   localparam int ONE = 1 << 16;

   initial begin
      logic [383:0] q;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      errors = 0; hits_seen = 0; rsp_count = 0; cycle = 0; hold_off = 0;
      eps_model = EPS_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed: plain crossing, same side, both on plane, zero normal, extremes
      query_q.push_back(make_query(0, 0, -ONE, 0, 0, ONE, 0, 0, 0, 0, 0, ONE));
      query_q.push_back(make_query(ONE, 2*ONE, -3*ONE, -ONE, 5*ONE, 7*ONE,
                                   0, 0, ONE, ONE, -ONE, ONE));
      query_q.push_back(make_query(0, 0, ONE, 0, 0, 2*ONE, 0, 0, 0, 0, 0, ONE));
      query_q.push_back(make_query(ONE, 0, 0, 5*ONE, 0, 0, 0, 0, 0, 0, 0, ONE));
      query_q.push_back(make_query(ONE, 2, 3, -ONE, 4, 5, 0, 0, 0, 0, 0, 0));
      query_q.push_back(make_query(0, 0, 0, 0, 0, 2*ONE, 0, 0, 0, 0, 0, ONE));
      query_q.push_back(make_query(0, 0, -1, 0, 0, 1, 0, 0, 0, 0, 0, ONE));
      query_q.push_back({12{32'h8000_0000}});
      query_q.push_back({12{32'h7fff_ffff}});
      q = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 96'd0,
           32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
           32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
      query_q.push_back(q);
      query_q.push_back({{3{32'h8000_0000}}, 96'd0, {3{32'h7fff_ffff}}, {3{32'h8000_0000}}});
      query_q.push_back(~q);
      query_q.push_back({32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, {9{32'h5555_aaaa}}});
      for (int i = 0; i < 80; i++) query_q.push_back(rand_query());
      // pressure: receiver stalls long while the sender keeps offering
      hold_off = 300;
      write_epsilon('0);
      query_q.push_back(make_query(0, 0, -1, 0, 0, 1, 0, 0, 0, 0, 0, ONE));
      query_q.push_back(make_query(0, 0, 0, 0, 0, 2*ONE, 0, 0, 0, 0, 0, ONE));
      query_q.push_back(make_query(0, 0, 0, 0, 0, -2*ONE, 0, 0, 0, 0, 0, ONE));
      for (int i = 0; i < 100; i++) query_q.push_back(rand_query());
      write_epsilon({EPS_W{1'b1}});
      for (int i = 0; i < 40; i++) query_q.push_back(rand_query());
      write_epsilon(31'(ONE));
      for (int i = 0; i < 90; i++) query_q.push_back(rand_query());
      write_epsilon(31'($urandom_range(0, 1 << 20)));
      for (int i = 0; i < 90; i++) query_q.push_back(rand_query());
      wait (query_q.size() == 0 && !req_tvalid && crossing_q.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("%0d results checked, %0d of them crossings, over five epsilon settings",
               rsp_count, hits_seen);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
